// ----- sv/rgbcls_pkg.sv -----
// Shared types, constants and channel expansion functions for the RGB565 colour classifier.
package rgbcls_pkg;

    // Stream and register port widths
    localparam int PIX_W  = 16;
    localparam int OUT_W  = 32;
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;
    localparam int AVG_W  = 8;
    localparam int QUO_W  = 3 * AVG_W;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_SAMPLE_STEP = 2'd0;
    localparam logic [1:0] REG_COLOR_THR   = 2'd1;
    localparam logic [1:0] REG_DARK_LIMIT  = 2'd2;
    localparam logic [1:0] REG_MID_LIMIT   = 2'd3;

    // Register reset values
    localparam logic [7:0] RST_SAMPLE_STEP = 8'd8;
    localparam logic [7:0] RST_COLOR_THR   = 8'd80;
    localparam logic [7:0] RST_DARK_LIMIT  = 8'd60;
    localparam logic [7:0] RST_MID_LIMIT   = 8'd120;

    // Colour codes
    localparam logic [1:0] COLOR_UNKNOWN = 2'd0;
    localparam logic [1:0] COLOR_RED     = 2'd1;
    localparam logic [1:0] COLOR_GREEN   = 2'd2;
    localparam logic [1:0] COLOR_BLUE    = 2'd3;

    // Size classes
    localparam logic [5:0] SIZE_SMALL  = 6'd10;
    localparam logic [5:0] SIZE_MEDIUM = 6'd30;
    localparam logic [5:0] SIZE_LARGE  = 6'd60;

    typedef enum logic [1:0] {
        ST_ACC,     // taking pixels
        ST_DIV,     // serial division of the three sums
        ST_CLS      // classify and load the result register
    } state_t;

    // Datapath controls from the state decoder
    typedef struct packed {
        logic take_pixel;
        logic div_step;
        logic cls_load;
    } ctrl_t;

    // floor(c*255/31) = 8c + floor(7c/31); the fraction steps at fixed codes
    function automatic logic [7:0] expand5(input logic [4:0] c);
        logic [2:0] frac;
        frac = 3'(c >= 5'd5) + 3'(c >= 5'd9) + 3'(c >= 5'd14) + 3'(c >= 5'd18)
             + 3'(c >= 5'd23) + 3'(c >= 5'd27) + 3'(c == 5'd31);
        return {c, 3'b000} + 8'(frac);
    endfunction

    // floor(c*255/63) = 4c + floor(c/21)
    function automatic logic [7:0] expand6(input logic [5:0] c);
        logic [1:0] frac;
        frac = 2'(c >= 6'd21) + 2'(c >= 6'd42) + 2'(c == 6'd63);
        return {c, 2'b00} + 8'(frac);
    endfunction

endpackage

// ----- sv/rgb565_frame_color_classifier_unit.sv -----
// Top level: pixel accumulation, bit-serial averaging and colour/size classification.
// Throughput: one pixel per cycle within a frame.
// The last pixel of a frame stalls the input while the shared restoring divider works
// (one quotient bit a cycle, three channels in turn) and while the result is classified.
// The result is valid after the division and classify states, delayed further only
// while an earlier result waits in the output register.
// Reset: synchronous, active low; clears sums, count, phase, FSM and valid, registers to defaults.
module rgb565_frame_color_classifier_unit #(
    parameter int MAX_FRAME_PIXELS = 32768
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rgbcls_pkg::PIX_W-1:0]     s_tdata,   // [15:0] pixel
    input  logic                             s_tlast,   // frame_end
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [7:0] avg_red, [15:8] avg_green, [23:16] avg_blue, [25:24] color_code,
    // [31:26] size_estimate
    output logic [rgbcls_pkg::OUT_W-1:0]     m_tdata,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rgbcls_pkg::APB_AW-1:0]    paddr,
    input  logic [rgbcls_pkg::APB_DW-1:0]    pwdata,
    output logic [rgbcls_pkg::APB_DW-1:0]    prdata,
    output logic                             pready
);
    import rgbcls_pkg::*;

    localparam int CW = $clog2(MAX_FRAME_PIXELS + 1);
    localparam int SW = $clog2(255 * MAX_FRAME_PIXELS + 1);
    localparam int DW = CW + 7;
    localparam int MW = (SW > DW) ? SW : DW;
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_FRAME_PIXELS);

    state_t state_reg, state_next;
    ctrl_t  ctrl;

    logic [7:0]       step_reg, thr_reg, dark_reg, mid_reg;
    logic [SW-1:0]    red_sum_reg, green_sum_reg, blue_sum_reg;
    logic [SW-1:0]    red_sum_next, green_sum_next, blue_sum_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [7:0]       phase_reg, phase_next;
    logic [MW-1:0]    rem_reg, rem_next, div_reg, div_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [1:0]       ch_reg, ch_next;
    logic [2:0]       bit_reg, bit_next;
    logic             m_valid_reg, m_valid_next;
    logic [OUT_W-1:0] m_data_reg, m_data_next;

    logic             cfg_wr, out_free, div_last, sampled, ge;
    logic [7:0]       step_eff;
    logic [8:0]       phase_inc;
    logic [SW-1:0]    red_acc, green_acc, blue_acc;
    logic [CW-1:0]    count_acc;
    logic [7:0]       avg_r, avg_g, avg_b;
    logic [1:0]       code;
    logic [5:0]       size;
    logic [9:0]       bright3, dark3, mid3;

    assign cfg_wr   = psel && penable && pwrite;
    assign pready   = 1'b1;
    assign out_free = !m_valid_reg || m_tready;
    assign div_last = (ch_reg == 2'd2) && (bit_reg == 3'd0);

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= RST_SAMPLE_STEP;
            thr_reg  <= RST_COLOR_THR;
            dark_reg <= RST_DARK_LIMIT;
            mid_reg  <= RST_MID_LIMIT;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_SAMPLE_STEP: step_reg <= pwdata[7:0];
                REG_COLOR_THR:   thr_reg  <= pwdata[7:0];
                REG_DARK_LIMIT:  dark_reg <= pwdata[7:0];
                REG_MID_LIMIT:   mid_reg  <= pwdata[7:0];
                default:         ;
            endcase
        end
    end

    // Register read-back
    always_comb begin
        unique case (paddr[3:2])
            REG_SAMPLE_STEP: prdata = APB_DW'(step_reg);
            REG_COLOR_THR:   prdata = APB_DW'(thr_reg);
            REG_DARK_LIMIT:  prdata = APB_DW'(dark_reg);
            REG_MID_LIMIT:   prdata = APB_DW'(mid_reg);
            default:         prdata = '0;
        endcase
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_ACC:  if (s_tvalid && s_tlast) state_next = ST_DIV;
            ST_DIV:  if (div_last) state_next = ST_CLS;
            ST_CLS:  if (out_free) state_next = ST_ACC;
            default: state_next = ST_ACC;
        endcase
    end

    // State decode
    always_comb begin
        ctrl = '0;
        unique case (state_reg)
            ST_ACC:  ctrl.take_pixel = s_tvalid;
            ST_DIV:  ctrl.div_step   = 1'b1;
            ST_CLS:  ctrl.cls_load   = out_free;
            default: ctrl = '0;
        endcase
    end

    assign s_tready = (state_reg == ST_ACC);

    // Sampling decision and accumulation for the current pixel
    always_comb begin
        step_eff  = (step_reg == 8'd0) ? 8'd1 : step_reg;
        phase_inc = {1'b0, phase_reg} + 9'd1;
        sampled   = (phase_reg == 8'd0) && (count_reg < CNT_MAX);
        red_acc   = red_sum_reg;
        green_acc = green_sum_reg;
        blue_acc  = blue_sum_reg;
        count_acc = count_reg;
        if (sampled) begin
            red_acc   = red_sum_reg   + SW'(expand5(s_tdata[15:11]));
            green_acc = green_sum_reg + SW'(expand6(s_tdata[10:5]));
            blue_acc  = blue_sum_reg  + SW'(expand5(s_tdata[4:0]));
            count_acc = count_reg + CW'(1);
        end
    end

    // Frame state: updated per pixel, cleared once the result is loaded
    always_comb begin
        red_sum_next   = red_sum_reg;
        green_sum_next = green_sum_reg;
        blue_sum_next  = blue_sum_reg;
        count_next     = count_reg;
        phase_next     = phase_reg;
        if (ctrl.take_pixel) begin
            red_sum_next   = red_acc;
            green_sum_next = green_acc;
            blue_sum_next  = blue_acc;
            count_next     = count_acc;
            phase_next     = (phase_inc >= {1'b0, step_eff}) ? 8'd0 : phase_inc[7:0];
        end else if (ctrl.cls_load) begin
            red_sum_next   = '0;
            green_sum_next = '0;
            blue_sum_next  = '0;
            count_next     = '0;
            phase_next     = '0;
        end
    end

    // Restoring divider: one quotient bit per cycle, red then green then blue
    always_comb begin
        ge       = rem_reg >= div_reg;
        rem_next = rem_reg;
        div_next = div_reg;
        quo_next = quo_reg;
        ch_next  = ch_reg;
        bit_next = bit_reg;
        if (ctrl.take_pixel) begin
            rem_next = MW'(red_acc);
            div_next = MW'({count_acc, 7'b0});
            ch_next  = 2'd0;
            bit_next = 3'd7;
        end else if (ctrl.div_step) begin
            quo_next = {quo_reg[QUO_W-2:0], ge};
            if (bit_reg == 3'd0) begin
                // move on to the next channel's sum
                rem_next = (ch_reg == 2'd0) ? MW'(green_sum_reg) : MW'(blue_sum_reg);
                div_next = MW'({count_reg, 7'b0});
                ch_next  = ch_reg + 2'd1;
                bit_next = 3'd7;
            end else begin
                rem_next = ge ? rem_reg - div_reg : rem_reg;
                div_next = div_reg >> 1;
                bit_next = bit_reg - 3'd1;
            end
        end
    end

    // Classification from the three averages
    always_comb begin
        avg_r   = (count_reg == '0) ? 8'd0 : quo_reg[23:16];
        avg_g   = (count_reg == '0) ? 8'd0 : quo_reg[15:8];
        avg_b   = (count_reg == '0) ? 8'd0 : quo_reg[7:0];
        // floor(sum/3) < limit is the same as sum < 3*limit
        bright3 = 10'(avg_r) + 10'(avg_g) + 10'(avg_b);
        dark3   = 10'({dark_reg, 1'b0}) + 10'(dark_reg);
        mid3    = 10'({mid_reg, 1'b0}) + 10'(mid_reg);
        if (avg_r > avg_g && avg_r > avg_b && avg_r > thr_reg) begin
            code = COLOR_RED;
        end else if (avg_g > avg_r && avg_g > avg_b && avg_g > thr_reg) begin
            code = COLOR_GREEN;
        end else if (avg_b > avg_r && avg_b > avg_g && avg_b > thr_reg) begin
            code = COLOR_BLUE;
        end else begin
            code = COLOR_UNKNOWN;
        end
        if (bright3 < dark3) begin
            size = SIZE_SMALL;
        end else if (bright3 < mid3) begin
            size = SIZE_MEDIUM;
        end else begin
            size = SIZE_LARGE;
        end
    end

    // Output register
    always_comb begin
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_tready;
        if (ctrl.cls_load) begin
            m_data_next  = {size, code, avg_b, avg_g, avg_r};
            m_valid_next = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_ACC;
            red_sum_reg   <= '0;
            green_sum_reg <= '0;
            blue_sum_reg  <= '0;
            count_reg     <= '0;
            phase_reg     <= '0;
            ch_reg        <= '0;
            bit_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            red_sum_reg   <= red_sum_next;
            green_sum_reg <= green_sum_next;
            blue_sum_reg  <= blue_sum_next;
            count_reg     <= count_next;
            phase_reg     <= phase_next;
            ch_reg        <= ch_next;
            bit_reg       <= bit_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        rem_reg    <= rem_next;
        div_reg    <= div_next;
        quo_reg    <= quo_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ----- sv/rgbcls_checker.sv -----
// Port-level checker for the colour classifier and its bind to the top level.
module rgbcls_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          s_tlast,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [rgbcls_pkg::OUT_W-1:0]  m_tdata
);
    import rgbcls_pkg::*;

    // A stalled result keeps its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // The frame's last pixel starts the averaging, so input stalls next cycle
    a_end_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input taken during frame end processing");

    // A red result has red strictly above both other averages
    a_red_dom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[25:24] == COLOR_RED |->
            (m_tdata[7:0] > m_tdata[15:8]) && (m_tdata[7:0] > m_tdata[23:16]))
        else $error("red code without red dominance");

    // Size class is one of the three defined values
    a_size_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[31:26] == SIZE_SMALL || m_tdata[31:26] == SIZE_MEDIUM
                     || m_tdata[31:26] == SIZE_LARGE)
        else $error("size class out of range");

endmodule

bind rgb565_frame_color_classifier_unit rgbcls_checker u_rgbcls_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
